>>> rtl/core/nps_pkg.sv
// Shared types and field widths of the priority scheduler core.
`default_nettype none
package nps_pkg;

  localparam int unsigned ArrW   = 16;
  localparam int unsigned BurstW = 16;
  localparam int unsigned PrioW  = 8;
  localparam int unsigned EntryW = ArrW + BurstW + PrioW;
  localparam int unsigned PidxW  = 4;
  localparam int unsigned TimeW  = 21;
  localparam int unsigned IdleW  = 16;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 88;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_UPDATE,
    ST_OUT
  } state_e;

endpackage
`default_nettype wire

>>> rtl/core/nonpreemptive_priority_scheduler_core.sv
// Non-preemptive priority scheduler: table load, iterative scan and result stream.
// Operation: table entries are taken one per cycle; after the last entry each decision
//   scans the table through one compare unit, then updates, then hands off the result.
//   A decision with nothing ready first costs an extra scan and update.
// Throughput: one table at a time; the input is not ready during scheduling.
// Reset: control state, finished flags and counters clear at once; no memory sweep.
`default_nettype none
module nonpreemptive_priority_scheduler_core #(
  parameter int unsigned MAX_PROCESSES = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // arrival_time[15:0], burst_time[31:16], priority_level[39:32]
  input  wire logic [nps_pkg::InDataW-1:0]   s_axis_tdata_i,
  input  wire logic                          s_axis_tlast_i,   // last_process
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // process_index[3:0], completion_time[24:4], turnaround_time[45:25],
  // waiting_time[66:46], idle_total[82:67], zero fill [87:83]
  output logic [nps_pkg::OutDataW-1:0]       m_axis_tdata_o,
  output logic                               m_axis_tlast_o,   // last_result
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i
);

  localparam int unsigned IdxW  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int unsigned CntW  = $clog2(MAX_PROCESSES + 1);
  localparam int unsigned TickW = nps_pkg::ArrW + CntW;
  localparam int unsigned TW    = nps_pkg::TimeW;

  nps_pkg::state_e state_q, state_d;

  logic [nps_pkg::EntryW-1:0] mem_q [MAX_PROCESSES];
  logic [nps_pkg::EntryW-1:0] rd_q;

  logic [MAX_PROCESSES-1:0] fin_q, fin_d;
  logic [IdxW-1:0]  loaded_q, loaded_d;
  logic [CntW-1:0]  n_q, n_d;
  logic [CntW-1:0]  scan_q, scan_d;
  logic [CntW-1:0]  done_q, done_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic [nps_pkg::IdleW-1:0] idle_q, idle_d;

  logic                      best_ok_q, best_ok_d;
  logic [IdxW-1:0]           best_idx_q, best_idx_d;
  logic [nps_pkg::PrioW-1:0] best_prio_q, best_prio_d;
  logic [nps_pkg::ArrW-1:0]  best_arr_q, best_arr_d;
  logic [nps_pkg::BurstW-1:0] best_burst_q, best_burst_d;
  logic                      min_ok_q, min_ok_d;
  logic [nps_pkg::ArrW-1:0]  min_arr_q, min_arr_d;

  logic [TickW-1:0] comp_q, comp_d, tat_q, tat_d, wt_q, wt_d;
  logic             last_q, last_d;

  logic s_acc, m_acc, start_tab, rd_en, ev_en, ev_fin, ev_rdy;
  logic [IdxW-1:0] slot, rd_idx, ev_idx;
  logic [nps_pkg::ArrW-1:0]   ev_arr;
  logic [nps_pkg::BurstW-1:0] ev_burst;
  logic [nps_pkg::PrioW-1:0]  ev_prio;
  logic [TickW-1:0] wt_new;
  logic [IdxW+nps_pkg::PidxW-1:0] pidx_ext;
  logic [TickW+TW-1:0] comp_ext, tat_ext, wt_ext;

  assign s_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign m_acc  = m_axis_tvalid_o && m_axis_tready_i;
  assign slot   = loaded_q;
  assign start_tab = s_acc && (s_axis_tlast_i || (CntW'(slot) == CntW'(MAX_PROCESSES - 1)));

  assign rd_en  = (state_q == nps_pkg::ST_SCAN) && (scan_q < n_q);
  assign rd_idx = scan_q[IdxW-1:0];
  assign ev_en  = (state_q == nps_pkg::ST_SCAN) && (scan_q != '0);
  assign ev_idx = IdxW'(scan_q - CntW'(1));

  assign ev_arr   = rd_q[nps_pkg::ArrW-1:0];
  assign ev_burst = rd_q[nps_pkg::ArrW +: nps_pkg::BurstW];
  assign ev_prio  = rd_q[nps_pkg::ArrW+nps_pkg::BurstW +: nps_pkg::PrioW];
  assign ev_fin   = fin_q[ev_idx];
  assign ev_rdy   = !ev_fin && (TickW'(ev_arr) <= tick_q);
  assign wt_new   = tick_q - TickW'(best_arr_q);

  // Table memory: one write port for loading, one registered read port for the scan.
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      mem_q[slot] <= s_axis_tdata_i[nps_pkg::EntryW-1:0];
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_idx];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      nps_pkg::ST_LOAD:   if (start_tab) state_d = nps_pkg::ST_SCAN;
      nps_pkg::ST_SCAN:   if (scan_q == n_q) state_d = nps_pkg::ST_UPDATE;
      nps_pkg::ST_UPDATE: state_d = best_ok_q ? nps_pkg::ST_OUT : nps_pkg::ST_SCAN;
      nps_pkg::ST_OUT: begin
        if (m_acc) state_d = last_q ? nps_pkg::ST_LOAD : nps_pkg::ST_SCAN;
      end
      default: state_d = nps_pkg::ST_LOAD;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    case (state_q)
      nps_pkg::ST_LOAD: s_axis_tready_o = 1'b1;
      nps_pkg::ST_OUT:  m_axis_tvalid_o = 1'b1;
      default: begin
        s_axis_tready_o = 1'b0;
        m_axis_tvalid_o = 1'b0;
      end
    endcase
  end

  // Datapath: load bookkeeping, compare unit, tick/idle update and result formation.
  always_comb begin
    fin_d = fin_q;  loaded_d = loaded_q;  n_d = n_q;  scan_d = scan_q;
    done_d = done_q;  tick_d = tick_q;  idle_d = idle_q;
    best_ok_d = best_ok_q;  best_idx_d = best_idx_q;  best_prio_d = best_prio_q;
    best_arr_d = best_arr_q;  best_burst_d = best_burst_q;
    min_ok_d = min_ok_q;  min_arr_d = min_arr_q;
    comp_d = comp_q;  tat_d = tat_q;  wt_d = wt_q;  last_d = last_q;

    case (state_q)
      nps_pkg::ST_LOAD: begin
        if (s_acc) begin
          if (slot == '0) fin_d = '0;
          fin_d[slot] = 1'b0;
          loaded_d = slot + IdxW'(1);
          if (start_tab) begin
            n_d = CntW'(slot) + CntW'(1);
            loaded_d = '0;
            tick_d = '0;  idle_d = '0;  done_d = '0;
            scan_d = '0;  best_ok_d = 1'b0;  min_ok_d = 1'b0;
          end
        end
      end
      nps_pkg::ST_SCAN: begin
        if (scan_q != n_q) scan_d = scan_q + CntW'(1);
        if (ev_en) begin
          if (ev_rdy && (!best_ok_q || ev_prio > best_prio_q)) begin
            best_ok_d = 1'b1;  best_idx_d = ev_idx;  best_prio_d = ev_prio;
            best_arr_d = ev_arr;  best_burst_d = ev_burst;
          end
          if (!ev_fin && (!min_ok_q || ev_arr < min_arr_q)) begin
            min_ok_d = 1'b1;  min_arr_d = ev_arr;
          end
        end
      end
      nps_pkg::ST_UPDATE: begin
        if (best_ok_q) begin
          tick_d = tick_q + TickW'(best_burst_q);
          comp_d = tick_q + TickW'(best_burst_q);
          wt_d   = wt_new;
          tat_d  = wt_new + TickW'(best_burst_q);
          fin_d[best_idx_q] = 1'b1;
          done_d = done_q + CntW'(1);
          last_d = (done_q + CntW'(1)) == n_q;
        end else begin
          // Nothing ready: jump to the earliest pending arrival.
          idle_d = idle_q + nps_pkg::IdleW'(TickW'(min_arr_q) - tick_q);
          tick_d = TickW'(min_arr_q);
          scan_d = '0;  best_ok_d = 1'b0;  min_ok_d = 1'b0;
        end
      end
      nps_pkg::ST_OUT: begin
        if (m_acc && !last_q) begin
          scan_d = '0;  best_ok_d = 1'b0;  min_ok_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= nps_pkg::ST_LOAD;
      fin_q     <= '0;
      loaded_q  <= '0;
      n_q       <= '0;
      scan_q    <= '0;
      done_q    <= '0;
      tick_q    <= '0;
      idle_q    <= '0;
      best_ok_q <= 1'b0;
      min_ok_q  <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      fin_q     <= fin_d;
      loaded_q  <= loaded_d;
      n_q       <= n_d;
      scan_q    <= scan_d;
      done_q    <= done_d;
      tick_q    <= tick_d;
      idle_q    <= idle_d;
      best_ok_q <= best_ok_d;
      min_ok_q  <= min_ok_d;
      last_q    <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_idx_q   <= best_idx_d;
    best_prio_q  <= best_prio_d;
    best_arr_q   <= best_arr_d;
    best_burst_q <= best_burst_d;
    min_arr_q    <= min_arr_d;
    comp_q       <= comp_d;
    tat_q        <= tat_d;
    wt_q         <= wt_d;
  end

  assign pidx_ext = {{nps_pkg::PidxW{1'b0}}, best_idx_q};
  assign comp_ext = {{TW{1'b0}}, comp_q};
  assign tat_ext  = {{TW{1'b0}}, tat_q};
  assign wt_ext   = {{TW{1'b0}}, wt_q};

  assign m_axis_tdata_o = {5'b0,
                           (last_q ? idle_q : {nps_pkg::IdleW{1'b0}}),
                           wt_ext[TW-1:0],
                           tat_ext[TW-1:0],
                           comp_ext[TW-1:0],
                           pidx_ext[nps_pkg::PidxW-1:0]};
  assign m_axis_tlast_o = last_q;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while a result is pending");

  a_start_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && s_axis_tlast_i) |=> (state_q == nps_pkg::ST_SCAN))
    else $error("last table entry did not start the scan");

  a_last_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && last_q) |-> (done_q == n_q))
    else $error("last result before all processes completed");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nps_pkg::ST_SCAN) |-> (scan_q <= n_q && done_q < n_q))
    else $error("scan counter out of range");

  a_out_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> best_ok_q)
    else $error("result without a selected process");

endmodule
`default_nettype wire
